>>> hw/rtl/tmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_pkg: shared constants and types for the trimmed-mean filter
// Window geometry, derived widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int DEPTH    = 6;
  localparam int CHANNELS = 8;
  localparam int BANKS    = 2;
  localparam int PAIRS    = BANKS * CHANNELS;

  localparam int SAMPLE_W = 16;
  localparam int BANK_W   = 1;
  localparam int CHAN_W   = 3;

  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int POS_W    = $clog2(DEPTH);
  localparam int PAIR_W   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int ADDR_W   = (PAIRS * DEPTH > 1) ? $clog2(PAIRS * DEPTH) : 1;

  // window sum plus one spare bit so the magnitude of any trimmed sum fits
  localparam int SUM_W    = SAMPLE_W + $clog2(DEPTH) + 1;

  localparam int TRIM_DIV = DEPTH - 2;

  // reciprocal for the constant divide, exact for every SUM_W-bit magnitude
  localparam int RECIP_SH = SUM_W + $clog2(TRIM_DIV);
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((longint'(1) << RECIP_SH) + longint'(TRIM_DIV) - 1) / longint'(TRIM_DIV));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_DRAIN,
    ST_TRIM,
    ST_DIV,
    ST_DONE
  } tmf_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/multichannel_trimmed_mean_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_filter_unit: per-channel olympic mean filter
// Keeps a window of DEPTH samples for each bank/channel pair and returns the
// window mean with the largest and smallest entry removed.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, bank, channel, sample): one sample per
//   transfer; in_ready is high only while the sequencer is idle. Output
//   channel (out_valid/out_ready, filtered, warming): one result per input.
//   Warming items (window not yet full, or bank/channel out of range): store
//   when in range, then load, with no reads and no division. Full-window
//   items: store, DEPTH reads through the single RAM read port, drain,
//   three divider stages (the first also trims), capture, load. A new
//   input can be taken in the cycle after the result is loaded, even while
//   that result still waits for out_ready; if the receiver stalls, the next
//   result is held in the sequencer until the output register frees up.
//   Reset (rst, synchronous) empties every window and rewinds write
//   positions; RAM contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean_filter_unit import tmf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [BANK_W-1:0]          bank,
  input  wire logic [CHAN_W-1:0]          channel,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      filtered,
  output logic                            warming
);

  tmf_state_t state, state_next;

  logic [BANK_W-1:0]          bank_r;
  logic [CHAN_W-1:0]          channel_r;
  logic signed [SAMPLE_W-1:0] sample_r;

  logic [FILL_W-1:0] fill_count     [PAIRS];
  logic [POS_W-1:0]  write_position [PAIRS];

  logic [POS_W-1:0]           slot;
  logic                       rd_vld;
  logic                       rd_first;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] hi;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] result_r;
  logic                       warm_r;

  logic                       in_range;
  logic [PAIR_W-1:0]          pair;
  logic [ADDR_W-1:0]          base;
  logic [FILL_W-1:0]          cur_fill;
  logic [POS_W-1:0]           cur_pos;
  logic                       ram_we;
  logic [ADDR_W-1:0]          waddr;
  logic [ADDR_W-1:0]          raddr;
  logic signed [SAMPLE_W-1:0] rdata;
  logic signed [SUM_W-1:0]    rd_ext;
  logic signed [SUM_W-1:0]    trim_sum;
  logic                       rd_issue;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] quotient;
  logic                       out_load;

  always_comb begin
    in_range = (int'(bank_r) < BANKS) && (int'(channel_r) < CHANNELS);
    pair     = in_range ? PAIR_W'(int'(bank_r) * CHANNELS + int'(channel_r)) : '0;
    base     = ADDR_W'(int'(pair) * DEPTH);
    cur_fill = fill_count[pair];
    cur_pos  = write_position[pair];
    ram_we   = (state == ST_UPDATE) && in_range;
    waddr    = base + ADDR_W'(cur_pos);
    raddr    = base + ADDR_W'(slot);
    rd_ext   = {{(SUM_W-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
    trim_sum = sum - {{(SUM_W-SAMPLE_W){hi[SAMPLE_W-1]}}, hi}
                   - {{(SUM_W-SAMPLE_W){lo[SAMPLE_W-1]}}, lo};
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  tmf_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (sample_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  tmf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trim_sum),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_issue   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (in_range && (cur_fill == FILL_W'(DEPTH))) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        rd_issue = 1'b1;
        if (slot == POS_W'(DEPTH - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_TRIM;
      end
      ST_TRIM: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // per-pair window bookkeeping, read tracking and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAIRS; i++) begin
        fill_count[i]     <= '0;
        write_position[i] <= '0;
      end
      rd_vld    <= 1'b0;
      rd_first  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld   <= rd_issue;
      rd_first <= rd_issue && (slot == '0);
      if (ram_we) begin
        write_position[pair] <= (cur_pos == POS_W'(DEPTH - 1)) ? '0 : cur_pos + 1'b1;
        if (cur_fill != FILL_W'(DEPTH)) begin
          fill_count[pair] <= cur_fill + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      bank_r    <= bank;
      channel_r <= channel;
      sample_r  <= sample;
    end
    if (state == ST_UPDATE) begin
      result_r <= sample_r;
      warm_r   <= 1'b1;
      slot     <= '0;
    end
    if (rd_issue) begin
      slot <= slot + 1'b1;
    end
    // read data arrives in the cycle after its address
    if (rd_vld) begin
      if (rd_first) begin
        sum <= rd_ext;
        hi  <= rdata;
        lo  <= rdata;
      end else begin
        sum <= sum + rd_ext;
        if (rdata > hi) begin
          hi <= rdata;
        end
        if (rdata < lo) begin
          lo <= rdata;
        end
      end
    end
    if ((state == ST_DIV) && div_done) begin
      result_r <= quotient;
      warm_r   <= 1'b0;
    end
    if (out_load) begin
      filtered <= result_r;
      warming  <= warm_r;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tmf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_ram: window sample storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmf_ram import tmf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic signed [SAMPLE_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]          raddr,
  output logic signed [SAMPLE_W-1:0]      rdata
);

  logic signed [SAMPLE_W-1:0] mem [PAIRS*DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/tmf_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_divider: divide the trimmed sum by DEPTH-2
// Three-stage reciprocal multiplication on the magnitude, truncates toward zero.
// ----------------------------------------------------------------------------
module tmf_divider import tmf_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [SUM_W-1:0]    dividend,
  output logic                            done,
  output logic signed [SAMPLE_W-1:0]      quotient
);

  logic              stage1;
  logic              stage2;
  logic              neg;
  logic [SUM_W-1:0]  mag_r;
  logic [SUM_W-1:0]  q_mag;

  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q_signed;

  always_comb begin
    mag      = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    prod     = PROD_W'(mag_r) * PROD_W'(RECIP_M);
    q_signed = neg ? SUM_W'(-q_mag) : q_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= mag;
      neg   <= dividend[SUM_W-1];
    end
    if (stage1) begin
      q_mag <= SUM_W'(prod >> RECIP_SH);
    end
    if (stage2) begin
      quotient <= q_signed[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tmf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmf_checker: port-level checks for the trimmed-mean filter
// Tracks items in flight and checks the handshakes of the two channels.
// ----------------------------------------------------------------------------
module tmf_checker import tmf_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [SAMPLE_W-1:0] filtered,
  input wire logic                       warming
);

  logic [1:0] pending;
  logic       in_xfer;
  logic       out_xfer;

  always_comb begin
    in_xfer  = in_valid && in_ready;
    out_xfer = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  // one item at a time: no second transfer right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken while previous item still in work");

  // no result without a matching input
  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 2'd0))
    else $error("result shown with no item in flight");

  // at most one item in work plus one waiting result
  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd0) || (pending == 2'd1) || (pending == 2'd2))
    else $error("too many items in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(filtered) && $stable(warming)))
    else $error("stalled result changed");

endmodule

bind multichannel_trimmed_mean_filter_unit tmf_checker u_tmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .filtered  (filtered),
  .warming   (warming)
);
`default_nettype wire

>>> tb/tmf_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_window_checker: result checker for the trimmed-mean filter
// Mirrors every bank/channel window from the input transfers it observes,
// predicts each result and compares it with the output transfers in order.
// ----------------------------------------------------------------------------
module tmf_window_checker import tmf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [BANK_W-1:0]          bank,
  input  logic [CHAN_W-1:0]          channel,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] filtered,
  input  logic                       warming,
  output int                         outstanding,
  output int                         errors,
  output int                         checked,
  output int                         trimmed
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       warming;
  } filt_result_t;

  filt_result_t owed_results[$];

  logic [FILL_W-1:0]          fill_cnt [PAIRS];
  logic [POS_W-1:0]           wr_pos   [PAIRS];
  logic signed [SAMPLE_W-1:0] win      [PAIRS][DEPTH];

  int err_cnt  = 0;
  int chk_cnt  = 0;
  int trim_cnt = 0;

  assign errors  = err_cnt;
  assign checked = chk_cnt;
  assign trimmed = trim_cnt;

  // store the sample in its window and work out what the block must return
  function automatic filt_result_t window_update(input logic [BANK_W-1:0] b,
                                                 input logic [CHAN_W-1:0] c,
                                                 input logic signed [SAMPLE_W-1:0] s);
    filt_result_t r;
    int p;
    int sum;
    int hi;
    int lo;
    r.filtered = s;
    r.warming  = 1'b1;
    if (b < BANKS && c < CHANNELS) begin
      p = int'(b) * CHANNELS + int'(c);
      win[p][wr_pos[p]] = s;
      wr_pos[p] = (wr_pos[p] == POS_W'(DEPTH - 1)) ? '0 : wr_pos[p] + 1'b1;
      if (fill_cnt[p] < FILL_W'(DEPTH)) begin
        fill_cnt[p] = fill_cnt[p] + 1'b1;
      end else begin
        sum = 0;
        hi  = win[p][0];
        lo  = win[p][0];
        for (int i = 0; i < DEPTH; i++) begin
          sum += win[p][i];
          if (win[p][i] > hi) hi = win[p][i];
          if (win[p][i] < lo) lo = win[p][i];
        end
        // one copy of max and min dropped; int division truncates toward zero
        r.filtered = SAMPLE_W'((sum - hi - lo) / TRIM_DIV);
        r.warming  = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    filt_result_t want;
    if (rst) begin
      owed_results.delete();
      for (int p = 0; p < PAIRS; p++) begin
        fill_cnt[p] = '0;
        wr_pos[p]   = '0;
      end
      outstanding <= 0;
    end else begin
      // retire before push: a result can never belong to this edge's input
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: result with nothing pending: filtered=%0d warming=%0b",
                     $realtime, filtered, warming);
          err_cnt++;
        end else begin
          want = owed_results.pop_front();
          chk_cnt++;
          if (!want.warming) trim_cnt++;
          if (filtered !== want.filtered || warming !== want.warming) begin
            if (err_cnt < 10)
              $display("%0t: mismatch: filtered exp %0d got %0d, warming exp %0b got %0b",
                       $realtime, want.filtered, filtered, want.warming, warming);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready)
        owed_results.push_back(window_update(bank, channel, sample));
      outstanding <= owed_results.size();
    end
  end

endmodule

>>> tb/multichannel_trimmed_mean_filter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_trimmed_mean_filter_unit_tb: top level for the filter unit
// Fills windows with extremes and ties, then streams random samples over all
// bank/channel pairs under changing idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module multichannel_trimmed_mean_filter_unit_tb import tmf_pkg::*;;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 2 * (DEPTH + SUM_W + 5);
  localparam int HOLD_CYCLES  = 300;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic [BANK_W-1:0]          bank      = '0;
  logic [CHAN_W-1:0]          channel   = '0;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic                       out_ready = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       warming;

  int outstanding;
  int errors;
  int checked;
  int trimmed;

  int   tx_idle_pct  = 38;
  int   rx_idle_pct  = 79;
  logic rx_hold_go   = 1'b0;
  int   rx_hold_left = 0;
  int   cycle_count  = 0;
  int   sent         = 0;

  multichannel_trimmed_mean_filter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .bank      (bank),
    .channel   (channel),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .filtered  (filtered),
    .warming   (warming)
  );

  tmf_window_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bank        (bank),
    .channel     (channel),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .filtered    (filtered),
    .warming     (warming),
    .outstanding (outstanding),
    .errors      (errors),
    .checked     (checked),
    .trimmed     (trimmed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver stall, counted down on its own
  always @(posedge clk) begin
    if (rx_hold_go)
      rx_hold_left <= HOLD_CYCLES;
    else if (rx_hold_left > 0)
      rx_hold_left <= rx_hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
  end

  // valid stays up across back-to-back transfers; only a gap lowers it
  task automatic offer(input logic [BANK_W-1:0] b, input logic [CHAN_W-1:0] c,
                       input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    bank     <= b;
    channel  <= c;
    sample   <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic offer_random();
    logic [BANK_W-1:0]          b;
    logic [CHAN_W-1:0]          c;
    logic signed [SAMPLE_W-1:0] s;
    int                         kind;
    b    = BANK_W'($urandom_range(BANKS - 1));
    c    = CHAN_W'($urandom_range(CHANNELS - 1));
    kind = $urandom_range(99);
    if (kind < 50)
      s = SAMPLE_W'($urandom);
    else if (kind < 70)
      s = SAMPLE_W'(int'($urandom_range(40)) - 20);  // small values, many ties
    else if (kind < 85)
      s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    else if ($urandom_range(1))
      s = SAMPLE_W'(32767 - int'($urandom_range(15)));
    else
      s = SAMPLE_W'(-32768 + int'($urandom_range(15)));
    offer(b, c, s);
  endtask

  // sender pauses until every transfer has its result back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (n) offer_random();
    drain();
  endtask

  initial begin
    int ties[7] = '{5, -7, 5, -7, 100, -100, 3};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // full-scale windows, then a window with tied values and a negative mean
    repeat (7) offer(1'b0, 3'd0, 16'sh7FFF);
    repeat (7) offer(1'b1, 3'd7, 16'sh8000);
    foreach (ties[i]) offer(1'b0, 3'd3, SAMPLE_W'(ties[i]));
    offer(1'b1, 3'd2, 16'sh5555);
    offer(1'b1, 3'd2, 16'shAAAA);
    offer(1'b0, 3'd5, 16'sh0000);
    offer(1'b0, 3'd6, 16'shFFFF);
    drain();

    run_phase(280, 38, 79);
    run_phase(280, 79, 38);

    // no idling; output held off while the sender keeps pushing
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    rx_hold_go  <= 1'b1;
    @(posedge clk);
    rx_hold_go  <= 1'b0;
    repeat (290) offer_random();
    drain();

    $display("covered %0d samples over %0d bank/channel windows, incl. a %0d-cycle stall",
             sent, PAIRS, HOLD_CYCLES);
    $display("%0d results compared (%0d trimmed, %0d pass-through), %0d mismatches",
             checked, trimmed, checked - trimmed, errors);
    if (errors == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
